@@ rtl/core/ttdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ttdr_pkg: shared types and helpers for the transposition table
// Item and entry layouts, queue sizing and the mate score adjustment.
// ----------------------------------------------------------------------------
package ttdr_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam logic [14:0] MATE_THRESHOLD_RST = 15'd31000;

   // Front-to-back queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Adjustment direction: toward root adds plies to positive mate scores
   localparam logic DIR_TO_ROOT   = 1'b1;
   localparam logic DIR_FROM_ROOT = 1'b0;

   typedef enum logic {
      KIND_PROBE = 1'b0,
      KIND_STORE = 1'b1
   } kind_type;

   // One classified command as it travels through the queue
   typedef struct packed {
      kind_type    kind;
      logic [63:0] hash;
      logic [7:0]  depth;
      logic [7:0]  plies;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [15:0] move;
   } item_type;

   // One table slot
   typedef struct packed {
      logic        valid;
      logic [63:0] hash;
      logic [7:0]  depth;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [15:0] move;
   } entry_type;

   // Move a mate score by plies; non-mate scores pass unchanged.
   // A zero score under a zero threshold counts as a negative mate.
   function automatic logic [15:0] shift_mate(input logic [15:0] score,
                                              input logic [7:0]  plies,
                                              input logic [14:0] thr,
                                              input logic        toward_root);
      logic [15:0] mag;
      logic        positive;
      logic [15:0] res;
      mag      = score[15] ? (~score + 16'd1) : score;
      positive = !score[15] && (score != 16'd0);
      res      = score;
      if (mag >= {1'b0, thr}) begin
         if (positive == toward_root) begin
            res = score + {8'd0, plies};
         end else begin
            res = score - {8'd0, plies};
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/core/ttdr_front.sv @@
// ----------------------------------------------------------------------------
// ttdr_front: command intake
// Accepts requests, classifies them and pre-adjusts store scores so that
// mate scores enter the table ply-independent.
// ----------------------------------------------------------------------------
module ttdr_front import ttdr_pkg::*; (
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [63:0]        req_position_hash,
   input  logic [7:0]         req_search_depth,
   input  logic [7:0]         req_ply_count,
   input  logic signed [15:0] req_eval_score,
   input  logic [1:0]         req_bound_type,
   input  logic [15:0]        req_move_code,
   input  logic [14:0]        mate_thr,
   input  logic               queue_full,
   input  logic               clearing,
   output logic               push,
   output item_type           push_item
);

   // Hold off while the table clears or the queue has no room
   assign busy = queue_full | clearing;
   assign push = start & ~busy;

   // Build the queued command; stores get their mate score made absolute
   always_comb begin
      push_item.kind  = kind_type'(req_kind);
      push_item.hash  = req_position_hash;
      push_item.depth = req_search_depth;
      push_item.plies = req_ply_count;
      push_item.bound = req_bound_type;
      push_item.move  = req_move_code;
      if (kind_type'(req_kind) == KIND_STORE) begin
         push_item.score = shift_mate(req_eval_score, req_ply_count, mate_thr,
                                      DIR_TO_ROOT);
      end else begin
         push_item.score = req_eval_score;
      end
   end

endmodule

@@ rtl/core/ttdr_queue.sv @@
// ----------------------------------------------------------------------------
// ttdr_queue: command queue between front and back
// Small FIFO so that intake and table access stall independently.
// ----------------------------------------------------------------------------
module ttdr_queue import ttdr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type              store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = store_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Capture the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/ttdr_back.sv @@
// ----------------------------------------------------------------------------
// ttdr_back: table access engine
// Owns the slot memory. Clears it after reset, then runs each command as a
// registered read followed by a compare/write and issues probe responses.
// ----------------------------------------------------------------------------
module ttdr_back import ttdr_pkg::*; #(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  item_type           head_item,
   output logic               pop,
   output logic               clearing,
   input  logic [14:0]        mate_thr,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [7:0]         rsp_found_depth,
   output logic signed [15:0] rsp_found_score,
   output logic [1:0]         rsp_found_type,
   output logic [15:0]        rsp_found_move
);

   localparam int SLOT_COUNT = 1 << INDEX_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type              state_ff;
   logic [INDEX_BITS-1:0]  clr_cnt_ff;
   item_type               cur_ff;
   entry_type              rd_ff;
   entry_type              mem [SLOT_COUNT];

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [7:0]             rsp_depth_ff;
   logic [15:0]            rsp_score_ff;
   logic [1:0]             rsp_type_ff;
   logic [15:0]            rsp_move_ff;

   logic                   wr_en;
   logic [INDEX_BITS-1:0]  wr_addr;
   entry_type              wr_data;
   logic                   hit;
   logic                   replace;

   assign clearing = (state_ff == ST_CLEAR);
   assign pop      = (state_ff == ST_IDLE) && head_valid;

   // Classify the slot just read against the current command
   assign hit     = rd_ff.valid && (rd_ff.hash == cur_ff.hash);
   assign replace = !rd_ff.valid || (cur_ff.depth >= rd_ff.depth);

   // Select the write: clearing sweep or a winning store
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff.hash[INDEX_BITS-1:0];
      wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
         end
         ST_EXEC: begin
            wr_en         = (cur_ff.kind == KIND_STORE) && replace;
            wr_data.valid = 1'b1;
            wr_data.hash  = cur_ff.hash;
            wr_data.depth = cur_ff.depth;
            wr_data.score = cur_ff.score;
            wr_data.bound = cur_ff.bound;
            wr_data.move  = cur_ff.move;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= mem[head_item.hash[INDEX_BITS-1:0]];
      end
   end

   // Sequencer with registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (head_valid) begin
                  cur_ff   <= head_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_IDLE;
               if (cur_ff.kind == KIND_PROBE) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit;
                  if (hit) begin
                     rsp_depth_ff <= rd_ff.depth;
                     rsp_score_ff <= shift_mate(rd_ff.score, cur_ff.plies, mate_thr,
                                                DIR_FROM_ROOT);
                     rsp_type_ff  <= rd_ff.bound;
                     rsp_move_ff  <= rd_ff.move;
                  end else begin
                     rsp_depth_ff <= '0;
                     rsp_score_ff <= '0;
                     rsp_type_ff  <= '0;
                     rsp_move_ff  <= '0;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_depth = rsp_depth_ff;
   assign rsp_found_score = rsp_score_ff;
   assign rsp_found_type  = rsp_type_ff;
   assign rsp_found_move  = rsp_move_ff;

endmodule

@@ rtl/core/transposition_table_depth_replace.sv @@
// ----------------------------------------------------------------------------
// transposition_table_depth_replace: direct-mapped transposition table
// Probe and store commands against a depth-preferred table with mate score
// ply adjustment.
//
//   Channel | Ports                          | Transfer when
//   --------+--------------------------------+-----------------------------
//   request | start, busy, req_*             | start high and busy low
//   result  | rsp_valid, rsp_*               | rsp_valid high (one cycle)
//   config  | csr_valid, csr_ready, csr_data | csr_valid and csr_ready high
//
// The table engine runs each command as a registered memory read, then
// compare and write-back. With the engine free a probe result passes the
// queue, the registered read and the response register; a two-entry queue
// takes requests meanwhile. After reset busy stays high while the table
// is swept clear. Configuration is taken at any time; results cannot stall.
// ----------------------------------------------------------------------------
module transposition_table_depth_replace import ttdr_pkg::*; #(
   parameter int INDEX_BITS = INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [63:0]        req_position_hash,
   input  logic [7:0]         req_search_depth,
   input  logic [7:0]         req_ply_count,
   input  logic signed [15:0] req_eval_score,
   input  logic [1:0]         req_bound_type,
   input  logic [15:0]        req_move_code,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [7:0]         rsp_found_depth,
   output logic signed [15:0] rsp_found_score,
   output logic [1:0]         rsp_found_type,
   output logic [15:0]        rsp_found_move,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [14:0]        csr_data
);

   logic [14:0] mate_thr_ff;
   logic        push;
   item_type    push_item;
   logic        queue_full;
   logic        head_valid;
   item_type    head_item;
   logic        pop;
   logic        clearing;

   // Threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_thr_ff <= MATE_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         mate_thr_ff <= csr_data;
      end
   end

   ttdr_front u_front (
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_position_hash (req_position_hash),
      .req_search_depth  (req_search_depth),
      .req_ply_count     (req_ply_count),
      .req_eval_score    (req_eval_score),
      .req_bound_type    (req_bound_type),
      .req_move_code     (req_move_code),
      .mate_thr          (mate_thr_ff),
      .queue_full        (queue_full),
      .clearing          (clearing),
      .push              (push),
      .push_item         (push_item)
   );

   ttdr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ttdr_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .clearing        (clearing),
      .mate_thr        (mate_thr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_found_depth (rsp_found_depth),
      .rsp_found_score (rsp_found_score),
      .rsp_found_type  (rsp_found_type),
      .rsp_found_move  (rsp_found_move)
   );

endmodule

@@ rtl/core/ttdr_checker.sv @@
// ----------------------------------------------------------------------------
// ttdr_checker: port-level checks for the transposition table
// Watches reset behavior, result spacing and miss payloads.
// ----------------------------------------------------------------------------
module ttdr_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input logic [7:0]         rsp_found_depth,
   input logic signed [15:0] rsp_found_score,
   input logic [1:0]         rsp_found_type,
   input logic [15:0]        rsp_found_move
);

   // Table sweep keeps intake closed right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

   // No result directly after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");

   // Each command passes the idle and execute states, so results never come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in back-to-back cycles");

   // A miss returns a zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_found_depth == 8'd0 && rsp_found_score == 16'sd0
         && rsp_found_type == 2'd0 && rsp_found_move == 16'd0))
      else $error("miss with nonzero payload");

endmodule

bind transposition_table_depth_replace ttdr_checker u_ttdr_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_found_depth (rsp_found_depth),
   .rsp_found_score (rsp_found_score),
   .rsp_found_type  (rsp_found_type),
   .rsp_found_move  (rsp_found_move)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the depth-preferred transposition table
// Sends probe and store commands, mirrors the table and the mate score
// adjustment in a local model, and checks every probe result in order.
// Directed tests cover misses, hits, replacement and the mate score edges.
// Random traffic then runs under several thresholds over colliding hashes.
// ----------------------------------------------------------------------------
module tb_top import ttdr_pkg::*; ();

   localparam int SLOT_BITS     = INDEX_BITS_DEF;
   localparam int SLOT_COUNT    = 1 << SLOT_BITS;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;

   // One probe answer as it should leave the block
   typedef struct packed {
      logic        hit;
      logic [7:0]  depth;
      logic [15:0] score;
      logic [1:0]  bound;
      logic [15:0] move;
   } probe_answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_kind = 1'b0;
   logic [63:0]        req_position_hash = '0;
   logic [7:0]         req_search_depth = '0;
   logic [7:0]         req_ply_count = '0;
   logic signed [15:0] req_eval_score = '0;
   logic [1:0]         req_bound_type = '0;
   logic [15:0]        req_move_code = '0;
   logic               rsp_valid;
   logic               rsp_hit;
   logic [7:0]         rsp_found_depth;
   logic signed [15:0] rsp_found_score;
   logic [1:0]         rsp_found_type;
   logic [15:0]        rsp_found_move;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [14:0]        csr_data = '0;

   // Local copy of the table and the threshold
   logic [14:0]   mate_threshold = MATE_THRESHOLD_RST;
   bit            slot_used  [SLOT_COUNT];
   logic [63:0]   slot_key   [SLOT_COUNT];
   logic [7:0]    slot_depth [SLOT_COUNT];
   logic [15:0]   slot_score [SLOT_COUNT];
   logic [1:0]    slot_bound [SLOT_COUNT];
   logic [15:0]   slot_move  [SLOT_COUNT];

   probe_answer_type pending_answers[$];
   int               fail_count = 0;
   int               cycle_count = 0;
   bit               idle_enabled = 1'b1;

   transposition_table_depth_replace #(
      .INDEX_BITS(SLOT_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_position_hash(req_position_hash),
      .req_search_depth (req_search_depth),
      .req_ply_count    (req_ply_count),
      .req_eval_score   (req_eval_score),
      .req_bound_type   (req_bound_type),
      .req_move_code    (req_move_code),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_found_depth  (rsp_found_depth),
      .rsp_found_score  (rsp_found_score),
      .rsp_found_type   (rsp_found_type),
      .rsp_found_move   (rsp_found_move),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Move a mate score by the ply count; toward the root adds to positive scores
   function automatic logic [15:0] ply_adjust(input logic [15:0] score_bits,
                                             input logic [7:0]  plies,
                                             input bit          toward_root);
      int value;
      int magnitude;
      bit positive;
      value     = int'($signed(score_bits));
      magnitude = (value < 0) ? -value : value;
      if (magnitude < int'(mate_threshold)) begin
         return score_bits;
      end
      positive = (value > 0);
      if (positive == toward_root) begin
         return score_bits + {8'd0, plies};
      end
      return score_bits - {8'd0, plies};
   endfunction

   // Apply one accepted command to the table copy; queue the answer of a probe
   function automatic void apply_command(input item_type cmd);
      int               slot;
      probe_answer_type answer;
      slot   = int'(cmd.hash[SLOT_BITS-1:0]);
      answer = '0;
      if (cmd.kind == KIND_STORE) begin
         if (!slot_used[slot] || cmd.depth >= slot_depth[slot]) begin
            slot_used[slot]  = 1'b1;
            slot_key[slot]   = cmd.hash;
            slot_depth[slot] = cmd.depth;
            slot_score[slot] = ply_adjust(cmd.score, cmd.plies, 1'b1);
            slot_bound[slot] = cmd.bound;
            slot_move[slot]  = cmd.move;
         end
      end else begin
         if (slot_used[slot] && slot_key[slot] == cmd.hash) begin
            answer.hit   = 1'b1;
            answer.depth = slot_depth[slot];
            answer.score = ply_adjust(slot_score[slot], cmd.plies, 1'b0);
            answer.bound = slot_bound[slot];
            answer.move  = slot_move[slot];
         end
         pending_answers.push_back(answer);
      end
   endfunction

   function automatic item_type make_command(input kind_type kind, input logic [63:0] hash,
                                             input logic [7:0] depth, input logic [7:0] plies,
                                             input logic [15:0] score, input logic [1:0] bound,
                                             input logic [15:0] move);
      item_type cmd;
      cmd.kind  = kind;
      cmd.hash  = hash;
      cmd.depth = depth;
      cmd.plies = plies;
      cmd.score = score;
      cmd.bound = bound;
      cmd.move  = move;
      return cmd;
   endfunction

   // Send one command; call at a rising edge, returns at the edge of the transfer
   task automatic send_command(input item_type cmd);
      if (idle_enabled && $urandom_range(0, 99) < 27) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= cmd.kind;
      req_position_hash <= cmd.hash;
      req_search_depth  <= cmd.depth;
      req_ply_count     <= cmd.plies;
      req_eval_score    <= cmd.score;
      req_bound_type    <= cmd.bound;
      req_move_code     <= cmd.move;
      do @(posedge clock); while (busy !== 1'b0);
      apply_command(cmd);
   endtask

   // Hold off the sender until every probe answer is back and stores have drained
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [14:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mate_threshold = value;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string field_name, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d",
               $time, field_name, want, got);
   endtask

   // Check each result transfer against the oldest pending probe
   always @(posedge clock) begin : check_answers
      probe_answer_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected result, expected none, got hit %0b", $time, rsp_hit);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_hit !== want.hit) report_mismatch("hit", 64'(want.hit), 64'(rsp_hit));
            if (rsp_found_depth !== want.depth) begin
               report_mismatch("found_depth", 64'(want.depth), 64'(rsp_found_depth));
            end
            if (rsp_found_score !== want.score) begin
               report_mismatch("found_score", 64'($signed(want.score)), 64'(rsp_found_score));
            end
            if (rsp_found_type !== want.bound) begin
               report_mismatch("found_type", 64'(want.bound), 64'(rsp_found_type));
            end
            if (rsp_found_move !== want.move) begin
               report_mismatch("found_move", 64'(want.move), 64'(rsp_found_move));
            end
         end
      end
   end

   // Probe slots that were never written
   task automatic test_probe_miss();
      send_command(make_command(KIND_PROBE, 64'h0, 8'hFF, 8'h00, 16'h8000, 2'd3, 16'hFFFF));
      send_command(make_command(KIND_PROBE, '1, 8'h00, 8'hFF, 16'h7FFF, 2'd0, 16'h0000));
   endtask

   // Store at the all-ones hash, then hit it and miss on a colliding hash
   task automatic test_store_hit();
      send_command(make_command(KIND_STORE, '1, 8'd0, 8'hFF, 16'h0000, 2'd3, 16'hFFFF));
      send_command(make_command(KIND_PROBE, '1, 8'd0, 8'h00, 16'h0000, 2'd0, 16'h0000));
      send_command(make_command(KIND_PROBE, 64'h0000_0000_0000_FFFF, 8'd0, 8'd0, 16'h0,
                                2'd0, 16'h0));
   endtask

   // Shallower store is dropped, equal depth replaces
   task automatic test_depth_replacement();
      logic [63:0] first_key;
      logic [63:0] second_key;
      first_key  = 64'h0123_4567_89AB_1234;
      second_key = 64'hFEDC_BA98_7654_1234;
      send_command(make_command(KIND_STORE, first_key, 8'd10, 8'd0, 16'd120, 2'd1, 16'h1111));
      send_command(make_command(KIND_STORE, second_key, 8'd9, 8'd0, -16'sd55, 2'd2, 16'h2222));
      send_command(make_command(KIND_PROBE, first_key, 8'd0, 8'd0, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_STORE, second_key, 8'd10, 8'd3, -16'sd55, 2'd2, 16'h2222));
      send_command(make_command(KIND_PROBE, first_key, 8'd0, 8'd0, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_PROBE, second_key, 8'd0, 8'd0, 16'd0, 2'd0, 16'h0));
   endtask

   // Positive and negative mates, the most negative score and a wrapping store
   task automatic test_mate_adjust();
      send_command(make_command(KIND_STORE, 64'hA1, 8'd255, 8'd10, 16'sd31500, 2'd1, 16'h0A01));
      send_command(make_command(KIND_PROBE, 64'hA1, 8'd0, 8'd20, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_STORE, 64'hA2, 8'd255, 8'd5, -16'sd31500, 2'd2, 16'h0A02));
      send_command(make_command(KIND_PROBE, 64'hA2, 8'd0, 8'd255, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_STORE, 64'hA3, 8'd255, 8'd1, 16'h8000, 2'd3, 16'h0A03));
      send_command(make_command(KIND_PROBE, 64'hA3, 8'd0, 8'd0, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_STORE, 64'hA4, 8'd255, 8'd255, 16'h7FFF, 2'd0, 16'h0A04));
      send_command(make_command(KIND_PROBE, 64'hA4, 8'd0, 8'd0, 16'd0, 2'd0, 16'h0));
   endtask

   // Zero threshold makes a zero score a negative mate; top threshold leaves only extremes
   task automatic test_threshold_edges();
      wait_for_results();
      write_threshold(15'd0);
      send_command(make_command(KIND_STORE, 64'hB1, 8'd1, 8'd7, 16'd0, 2'd1, 16'h0B01));
      send_command(make_command(KIND_PROBE, 64'hB1, 8'd0, 8'd3, 16'd0, 2'd0, 16'h0));
      wait_for_results();
      write_threshold(15'h7FFF);
      send_command(make_command(KIND_STORE, 64'hB2, 8'd1, 8'd9, 16'h7FFF, 2'd2, 16'h0B02));
      send_command(make_command(KIND_PROBE, 64'hB2, 8'd0, 8'd9, 16'd0, 2'd0, 16'h0));
      send_command(make_command(KIND_STORE, 64'hB3, 8'd1, 8'd4, 16'h8000, 2'd3, 16'h0B03));
      send_command(make_command(KIND_PROBE, 64'hB3, 8'd0, 8'd200, 16'd0, 2'd0, 16'h0));
   endtask

   // Mostly store/probe traffic over a pool of colliding hashes, some random hashes
   task automatic test_random_traffic(input int item_count, input logic [14:0] threshold,
                                      input bit idle_on, input bit pause_midway);
      logic [63:0] hash_pool [32];
      logic [15:0] group_slot [8];
      item_type    cmd;
      int          score_value;
      wait_for_results();
      write_threshold(threshold);
      idle_enabled = idle_on;
      foreach (group_slot[g]) group_slot[g] = 16'($urandom);
      foreach (hash_pool[h]) begin
         hash_pool[h]        = {$urandom, $urandom};
         hash_pool[h][15:0]  = group_slot[h % 8];
      end
      for (int n = 0; n < item_count; n++) begin
         if (pause_midway && n == item_count / 2) wait_for_results();
         cmd.kind  = ($urandom_range(0, 99) < 45) ? KIND_STORE : KIND_PROBE;
         cmd.hash  = ($urandom_range(0, 99) < 85) ? hash_pool[$urandom_range(0, 31)]
                                                  : {$urandom, $urandom};
         cmd.depth = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
         cmd.plies = 8'($urandom);
         cmd.bound = 2'($urandom);
         cmd.move  = 16'($urandom);
         // Bias scores toward the threshold edges and the 16-bit extremes
         case ($urandom_range(0, 5))
            0: begin
               score_value = $urandom_range(0, 65535);
            end
            1: begin
               score_value = int'(threshold) + int'($urandom_range(0, 600)) - 300;
            end
            2: begin
               score_value = -int'(threshold) + int'($urandom_range(0, 600)) - 300;
            end
            3: begin
               score_value = 32767 - int'($urandom_range(0, 400));
            end
            4: begin
               score_value = -32768 + int'($urandom_range(0, 400));
            end
            default: begin
               score_value = int'($urandom_range(0, 20)) - 10;
            end
         endcase
         cmd.score = score_value[15:0];
         send_command(cmd);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_probe_miss();
      test_store_hit();
      test_depth_replacement();
      test_mate_adjust();
      test_threshold_edges();
      test_random_traffic(300, 15'd31000, 1'b1, 1'b0);
      test_random_traffic(300, 15'd0, 1'b1, 1'b1);
      test_random_traffic(350, 15'h7FFF, 1'b0, 1'b0);
      test_random_traffic(200, 15'd1, 1'b1, 1'b0);
      test_random_traffic(250, 15'($urandom_range(0, 32767)), 1'b1, 1'b0);
      wait_for_results();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
